// ===== design/hrc_pkg.sv =====
// Shared types and constants for the HSV/RGB color converter pipeline.
package hrc_pkg;

	localparam logic [7:0] SECTOR_W   = 8'd43;
	localparam logic [7:0] HUE_BASE_G = 8'd85;
	localparam logic [7:0] HUE_BASE_B = 8'd171;
	localparam logic [7:0] FULL_SCALE = 8'd255;
	localparam logic [7:0] REM_SCALE  = 8'd6;

	// Number of restoring-division stages (one quotient bit each)
	localparam int DIV_STEPS = 8;

	// Hue sectors of the HSV wheel
	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	// Channel that holds the maximum in RGB to HSV
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	localparam logic MODE_HSV2RGB = 1'b0;
	localparam logic MODE_RGB2HSV = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
	} hrc_in_t;

	typedef struct packed {
		logic [7:0] out_a;
		logic [7:0] out_b;
		logic [7:0] out_c;
	} hrc_out_t;

	// HSV to RGB operands after the first products
	typedef struct packed {
		logic [2:0]  region;
		logic        grey;
		logic [7:0]  v;
		logic [15:0] sr;
		logic [15:0] st;
		logic [15:0] pp;
	} hrc_hsv_t;

	// HSV to RGB levels after the second products
	typedef struct packed {
		logic [2:0] region;
		logic       grey;
		logic [7:0] v;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
	} hrc_lvl_t;

	// Per-item control that rides alongside the dividers
	typedef struct packed {
		logic       mode;
		logic       zero_s;
		logic       neg;
		logic [1:0] top_ch;
		logic [7:0] mx;
	} hrc_meta_t;

	// Two restoring dividers: saturation and hue offset
	typedef struct packed {
		logic [15:0] s_rem;
		logic [7:0]  s_den;
		logic [7:0]  s_quo;
		logic [15:0] h_rem;
		logic [7:0]  h_den;
		logic [7:0]  h_quo;
	} hrc_div_t;

endpackage

// ===== design/hsv_rgb_color_convert_top.sv =====
// HSV/RGB color converter: start is carried to done through stages s1, s2, the division stages and the done register.
// Throughput one pixel per clock; busy is always low, so start may be high every cycle.
// Depth is set by the eight one-bit division stages of the RGB to HSV path.
// done pulses for one cycle with the result; the receiver cannot stall it.
// arst_n clears every stage valid bit at once; data registers are not reset.
module hsv_rgb_color_convert_top import hrc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  hrc_in_t  item,
	output logic     done,
	output hrc_out_t result
);

	localparam int LAST = 2 + DIV_STEPS;

	logic      vld_s [2:LAST];
	hrc_div_t  div_s [2:LAST];
	hrc_meta_t meta_s [2:LAST];
	hrc_lvl_t  lvl_s [3:LAST];
	hrc_hsv_t  hsv_s2;

	hrc_meta_t m;
	hrc_lvl_t  l;
	hrc_div_t  d;
	hrc_out_t  res;
	logic [7:0] h_base, h_off;

	assign busy = 1'b0;

	hrc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start & ~busy),
		.item    (item),
		.vld_s2  (vld_s[2]),
		.hsv_s2  (hsv_s2),
		.meta_s2 (meta_s[2]),
		.div_s2  (div_s[2])
	);

	hrc_hsv_mul u_hsv_mul (
		.clk    (clk),
		.hsv    (hsv_s2),
		.lvl_s3 (lvl_s[3])
	);

	for (genvar i = 3; i <= LAST; i++) begin : g_div
		hrc_div_step #(.BIT(LAST - i)) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (vld_s[i-1]),
			.div    (div_s[i-1]),
			.vld_sn (vld_s[i]),
			.div_sn (div_s[i])
		);
	end

	// carry control and HSV levels alongside the dividers
	for (genvar i = 3; i <= LAST; i++) begin : g_meta
		always_ff @(posedge clk) begin
			meta_s[i] <= meta_s[i-1];
		end
	end

	for (genvar i = 4; i <= LAST; i++) begin : g_lvl
		always_ff @(posedge clk) begin
			lvl_s[i] <= lvl_s[i-1];
		end
	end

	always_comb begin
		m = meta_s[LAST];
		l = lvl_s[LAST];
		d = div_s[LAST];
		case (m.top_ch)
			CH_GREEN: h_base = HUE_BASE_G;
			CH_BLUE:  h_base = HUE_BASE_B;
			default:  h_base = 8'd0;
		endcase
		h_off = m.neg ? (8'd0 - d.h_quo) : d.h_quo;
		res = '0;
		if (m.mode == MODE_RGB2HSV) begin
			res.out_a = m.zero_s ? 8'd0 : (h_base + h_off);
			res.out_b = m.zero_s ? 8'd0 : d.s_quo;
			res.out_c = m.mx;
		end else if (l.grey) begin
			res.out_a = l.v;
			res.out_b = l.v;
			res.out_c = l.v;
		end else begin
			case (l.region)
				SEC_RY: res = '{out_a: l.v, out_b: l.t, out_c: l.p};
				SEC_YG: res = '{out_a: l.q, out_b: l.v, out_c: l.p};
				SEC_GC: res = '{out_a: l.p, out_b: l.v, out_c: l.t};
				SEC_CB: res = '{out_a: l.p, out_b: l.q, out_c: l.v};
				SEC_BM: res = '{out_a: l.t, out_b: l.p, out_c: l.v};
				default: res = '{out_a: l.v, out_b: l.p, out_c: l.q};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		result <= res;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(LAST + 1) done)
		else $error("accepted beat did not produce a result on time");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAST + 1))
		else $error("result strobe without a matching accepted beat");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAST] && meta_s[LAST].mode == MODE_RGB2HSV && !meta_s[LAST].zero_s)
		|-> (div_s[LAST].h_quo <= SECTOR_W))
		else $error("hue offset quotient out of range");

	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAST] && meta_s[LAST].mode == MODE_RGB2HSV && !meta_s[LAST].zero_s)
		|-> (div_s[LAST].s_rem < {8'd0, div_s[LAST].s_den}))
		else $error("saturation divider remainder not reduced");

endmodule

// ===== design/hrc_front.sv =====
// Front stages: channel decode (s1) and first products and dividends (s2).
module hrc_front import hrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vld,
	input  hrc_in_t   item,
	output logic      vld_s2,
	output hrc_hsv_t  hsv_s2,
	output hrc_meta_t meta_s2,
	output hrc_div_t  div_s2
);

	typedef struct packed {
		logic       mode;
		logic [2:0] region;
		logic [7:0] rem;
		logic [7:0] s;
		logic [7:0] v;
		logic [7:0] mx;
		logic [7:0] diff;
		logic [7:0] mag;
		logic       neg;
		logic [1:0] top_ch;
	} hrc_dec_t;

	logic     vld_s1;
	hrc_dec_t dec_s1;
	hrc_dec_t dec;
	logic [7:0] h_base;
	logic [5:0] h_off;
	logic [7:0] r, g, b, mn, x, y;

	always_comb begin
		dec = '0;
		dec.mode = item.mode;
		// sector of the hue wheel and its start
		if (item.chan_a < SECTOR_W) begin
			dec.region = SEC_RY;
			h_base = 8'd0;
		end else if (item.chan_a < 8'(2 * SECTOR_W)) begin
			dec.region = SEC_YG;
			h_base = SECTOR_W;
		end else if (item.chan_a < 8'(3 * SECTOR_W)) begin
			dec.region = SEC_GC;
			h_base = 8'(2 * SECTOR_W);
		end else if (item.chan_a < 8'(4 * SECTOR_W)) begin
			dec.region = SEC_CB;
			h_base = 8'(3 * SECTOR_W);
		end else if (item.chan_a < 8'(5 * SECTOR_W)) begin
			dec.region = SEC_BM;
			h_base = 8'(4 * SECTOR_W);
		end else begin
			dec.region = SEC_MR;
			h_base = 8'(5 * SECTOR_W);
		end
		h_off = 6'(item.chan_a - h_base);
		dec.rem = 8'({2'b00, h_off} * REM_SCALE);
		dec.s = item.chan_b;
		dec.v = item.chan_c;

		r = item.chan_a;
		g = item.chan_b;
		b = item.chan_c;
		mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
		dec.mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
		dec.diff = dec.mx - mn;
		// red wins ties, then green
		if (dec.mx == r) begin
			dec.top_ch = CH_RED;
			x = g;
			y = b;
		end else if (dec.mx == g) begin
			dec.top_ch = CH_GREEN;
			x = b;
			y = r;
		end else begin
			dec.top_ch = CH_BLUE;
			x = r;
			y = g;
		end
		dec.neg = (x < y);
		dec.mag = dec.neg ? (y - x) : (x - y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		dec_s1 <= dec;

		hsv_s2.region <= dec_s1.region;
		hsv_s2.grey   <= (dec_s1.s == 8'd0);
		hsv_s2.v      <= dec_s1.v;
		hsv_s2.sr     <= {8'd0, dec_s1.s} * {8'd0, dec_s1.rem};
		hsv_s2.st     <= {8'd0, dec_s1.s} * {8'd0, FULL_SCALE - dec_s1.rem};
		hsv_s2.pp     <= {8'd0, dec_s1.v} * {8'd0, FULL_SCALE - dec_s1.s};

		meta_s2.mode   <= dec_s1.mode;
		meta_s2.zero_s <= (dec_s1.diff == 8'd0);
		meta_s2.neg    <= dec_s1.neg;
		meta_s2.top_ch <= dec_s1.top_ch;
		meta_s2.mx     <= dec_s1.mx;

		// dividends 255*diff and 43*|d|; quotients start cleared
		div_s2.s_rem <= {dec_s1.diff, 8'd0} - {8'd0, dec_s1.diff};
		div_s2.s_den <= dec_s1.mx;
		div_s2.s_quo <= 8'd0;
		div_s2.h_rem <= {8'd0, dec_s1.mag} * {8'd0, SECTOR_W};
		div_s2.h_den <= dec_s1.diff;
		div_s2.h_quo <= 8'd0;
	end

endmodule

// ===== design/hrc_div_step.sv =====
// One restoring-division stage: resolves one quotient bit of both dividers.
module hrc_div_step import hrc_pkg::*; #(
	parameter int BIT = 7
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     vld,
	input  hrc_div_t div,
	output logic     vld_sn,
	output hrc_div_t div_sn
);

	logic [15:0] s_sh, h_sh;
	hrc_div_t    nxt;

	assign s_sh = {8'd0, div.s_den} << BIT;
	assign h_sh = {8'd0, div.h_den} << BIT;

	always_comb begin
		nxt = div;
		if (div.s_rem >= s_sh) begin
			nxt.s_rem = div.s_rem - s_sh;
			nxt.s_quo[BIT] = 1'b1;
		end
		if (div.h_rem >= h_sh) begin
			nxt.h_rem = div.h_rem - h_sh;
			nxt.h_quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= 1'b0;
		end else begin
			vld_sn <= vld;
		end
	end

	always_ff @(posedge clk) begin
		div_sn <= nxt;
	end

endmodule

// ===== design/hrc_hsv_mul.sv =====
// HSV to RGB second products: forms the p, q and t levels (one register stage).
module hrc_hsv_mul import hrc_pkg::*; (
	input  logic     clk,
	input  hrc_hsv_t hsv,
	output hrc_lvl_t lvl_s3
);

	logic [15:0] q_prod, t_prod;

	assign q_prod = {8'd0, hsv.v} * {8'd0, FULL_SCALE - hsv.sr[15:8]};
	assign t_prod = {8'd0, hsv.v} * {8'd0, FULL_SCALE - hsv.st[15:8]};

	always_ff @(posedge clk) begin
		lvl_s3.region <= hsv.region;
		lvl_s3.grey   <= hsv.grey;
		lvl_s3.v      <= hsv.v;
		lvl_s3.p      <= hsv.pp[15:8];
		lvl_s3.q      <= q_prod[15:8];
		lvl_s3.t      <= t_prod[15:8];
	end

endmodule
